// ===== src/vrlr_pkg.sv =====
`default_nettype none
package vrlr_pkg;

  localparam logic [2:0] OP_BEGIN = 3'd0;
  localparam logic [2:0] OP_DATA  = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_PEEK  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam int unsigned MinBufferBytes = 32;
  localparam int unsigned ResetBufferBytes = 4096;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  severity;
    logic [11:0] record_length;
    logic [47:0] timestamp_ms;
    logic [7:0]  data_byte;
    logic [11:0] peek_address;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  level_out;
    logic [11:0] length_out;
    logic [47:0] time_out;
    logic [11:0] data_offset;
    logic [7:0]  byte_out;
    logic [8:0]  records_held;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_DATA,
    CMD_CLEAR,
    CMD_FETCH,
    CMD_DROP,
    CMD_WRAP,
    CMD_HDR,
    CMD_COMMIT,
    CMD_RD_FIN,
    CMD_PEEK_RD,
    CMD_PEEK_FIN
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WRAP_CHK,
    ST_FREE_CHK,
    ST_FETCH,
    ST_FETCH_END,
    ST_DROP_W,
    ST_DROP_F,
    ST_HDR,
    ST_COMMIT,
    ST_RD_FIN,
    ST_PEEK_RD,
    ST_PEEK_FIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e cmd;
  } ctl_t;

  typedef struct packed {
    logic [2:0] op;
    logic       pend_zero;
    logic       too_long;
    logic       free_short;
    logic       tail_short;
    logic       wrap_drop;
    logic       rd_ok;
    logic       peek_ok;
    logic       fetch_last;
    logic       hdr_last;
  } stat_t;

endpackage
`default_nettype wire

// ===== src/vrlr_datapath.sv =====
`default_nettype none
module vrlr_datapath #(
  parameter int unsigned MAX_BUFFER_BYTES = 4096,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  vrlr_pkg::ctl_t      ctl_i,
  input  vrlr_pkg::in_item_t  item_i,
  input  wire                 cfg_we_i,
  input  wire  [12:0]         cfg_data_i,
  output vrlr_pkg::stat_t     stat_o,
  output vrlr_pkg::out_item_t result_o
);

  localparam int unsigned AW = $clog2(MAX_BUFFER_BYTES);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned SW = ((PW > 12) ? PW : 12) + 2;
  localparam int unsigned IW = $clog2(HEADER_BYTES);
  localparam int unsigned CW = (PW > 9) ? PW : 9;
  localparam int unsigned RstSize = (vrlr_pkg::ResetBufferBytes > MAX_BUFFER_BYTES) ?
                                    MAX_BUFFER_BYTES : vrlr_pkg::ResetBufferBytes;
  localparam logic [SW-1:0] HdrS = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] MaxS = SW'(MAX_BUFFER_BYTES);
  localparam logic [SW-1:0] MinS = SW'(vrlr_pkg::MinBufferBytes);
  localparam logic [IW-1:0] FetchLast = IW'(7);
  localparam logic [IW-1:0] HdrLast = IW'(HEADER_BYTES - 1);

  logic [PW-1:0] size_q, size_d, rp_q, rp_d, wp_q, wp_d, wrap_q, wrap_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [11:0]   pend_q, pend_d;
  logic [IW-1:0] idx_q, idx_d;
  vrlr_pkg::in_item_t  it_q;
  vrlr_pkg::out_item_t res_q, res_d;
  logic [63:0]   hdr_q;
  logic          rvld_q;
  logic [7:0]    mem [MAX_BUFFER_BYTES];
  logic [7:0]    rdata_q;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd;

  logic [SW-1:0] s_x, rp_x, wp_x, wrap_x, len_x, need_x, free_x, nrp_x, cfg_x, clamp_x, wpn_x;
  logic [11:0]   hlen;
  logic [PW-1:0] nxt_rp;

  always_comb begin
    s_x    = SW'(size_q);
    rp_x   = SW'(rp_q);
    wp_x   = SW'(wp_q);
    wrap_x = SW'(wrap_q);
    len_x  = SW'(it_q.record_length);
    need_x = len_x + HdrS;
    if (cnt_q == '0) begin
      free_x = s_x;
    end else if (wp_x > rp_x) begin
      free_x = (s_x > wp_x) ? (s_x - wp_x) : '0;
    end else begin
      free_x = rp_x - wp_x;
    end
    hlen   = {hdr_q[59:56], hdr_q[55:48]};
    nrp_x  = rp_x + HdrS + SW'(hlen);
    nxt_rp = ((nrp_x + HdrS > s_x) || (nrp_x >= wrap_x)) ? '0 : nrp_x[PW-1:0];
    wpn_x  = wp_x + need_x;
    cfg_x  = SW'(cfg_data_i);
    if (cfg_x < MinS) begin
      clamp_x = MinS;
    end else if (cfg_x > MaxS) begin
      clamp_x = MaxS;
    end else begin
      clamp_x = cfg_x;
    end
  end

  always_comb begin
    stat_o.op         = it_q.opcode;
    stat_o.pend_zero  = (pend_q == '0);
    stat_o.too_long   = (need_x > s_x);
    stat_o.free_short = (free_x < need_x);
    stat_o.tail_short = ((s_x - wp_x) < need_x);
    stat_o.wrap_drop  = (rp_x >= wp_x) && (cnt_q != '0);
    stat_o.rd_ok      = (pend_q == '0) && (cnt_q != '0) && (rp_x < wrap_x);
    stat_o.peek_ok    = (SW'(it_q.peek_address) < s_x);
    stat_o.fetch_last = (idx_q == FetchLast);
    stat_o.hdr_last   = (idx_q == HdrLast);
  end

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = wp_q[AW-1:0] + AW'(idx_q);
    mem_ra = rp_q[AW-1:0] + AW'(idx_q);
    mem_wd = '0;
    unique case (ctl_i.cmd)
      vrlr_pkg::CMD_DATA: begin
        mem_we = 1'b1;
        mem_wa = AW'(wp_x - SW'(pend_q));
        mem_wd = it_q.data_byte;
      end
      vrlr_pkg::CMD_HDR: begin
        mem_we = 1'b1;
        if (idx_q < IW'(6)) begin
          mem_wd = 8'(it_q.timestamp_ms >> {idx_q, 3'b000});
        end else if (idx_q == IW'(6)) begin
          mem_wd = it_q.record_length[7:0];
        end else if (idx_q == IW'(7)) begin
          mem_wd = {it_q.severity, it_q.record_length[11:8]};
        end
      end
      vrlr_pkg::CMD_FETCH: mem_re = 1'b1;
      vrlr_pkg::CMD_PEEK_RD: begin
        mem_re = 1'b1;
        mem_ra = AW'(SW'(it_q.peek_address));
      end
      default: ;
    endcase
  end

  always_comb begin
    size_d = size_q;
    rp_d   = rp_q;
    wp_d   = wp_q;
    wrap_d = wrap_q;
    cnt_d  = cnt_q;
    pend_d = pend_q;
    idx_d  = idx_q;
    res_d  = res_q;
    if (cfg_we_i) begin
      size_d = clamp_x[PW-1:0];
      rp_d   = '0;
      wp_d   = '0;
      wrap_d = clamp_x[PW-1:0];
      cnt_d  = '0;
      pend_d = '0;
    end else begin
      unique case (ctl_i.cmd)
        vrlr_pkg::CMD_LATCH: begin
          idx_d        = '0;
          res_d        = '0;
          res_d.status = 1'b1;
        end
        vrlr_pkg::CMD_DATA: begin
          pend_d       = pend_q - 12'd1;
          res_d.status = 1'b0;
        end
        vrlr_pkg::CMD_CLEAR: begin
          rp_d         = '0;
          wp_d         = '0;
          wrap_d       = size_q;
          cnt_d        = '0;
          pend_d       = '0;
          res_d.status = 1'b0;
        end
        vrlr_pkg::CMD_FETCH, vrlr_pkg::CMD_HDR: idx_d = idx_q + IW'(1);
        vrlr_pkg::CMD_DROP, vrlr_pkg::CMD_RD_FIN: begin
          idx_d = '0;
          cnt_d = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            rp_d   = '0;
            wp_d   = '0;
            wrap_d = size_q;
            pend_d = '0;
          end else begin
            rp_d = nxt_rp;
          end
          if (ctl_i.cmd == vrlr_pkg::CMD_RD_FIN) begin
            res_d.status      = 1'b0;
            res_d.level_out   = hdr_q[63:60];
            res_d.length_out  = hlen;
            res_d.time_out    = hdr_q[47:0];
            res_d.data_offset = 12'(rp_x + HdrS);
          end
        end
        vrlr_pkg::CMD_WRAP: begin
          idx_d  = '0;
          wrap_d = wp_q;
          wp_d   = '0;
        end
        vrlr_pkg::CMD_COMMIT: begin
          idx_d        = '0;
          wp_d         = wpn_x[PW-1:0];
          pend_d       = it_q.record_length;
          cnt_d        = cnt_q + CW'(1);
          if (wpn_x > wrap_x) wrap_d = wpn_x[PW-1:0];
          res_d.status = 1'b0;
        end
        vrlr_pkg::CMD_PEEK_FIN: begin
          res_d.status   = 1'b0;
          res_d.byte_out = rdata_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= PW'(RstSize);
      rp_q   <= '0;
      wp_q   <= '0;
      wrap_q <= PW'(RstSize);
      cnt_q  <= '0;
      pend_q <= '0;
      idx_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      size_q <= size_d;
      rp_q   <= rp_d;
      wp_q   <= wp_d;
      wrap_q <= wrap_d;
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      idx_q  <= idx_d;
      rvld_q <= mem_re;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (ctl_i.cmd == vrlr_pkg::CMD_LATCH) it_q <= item_i;
    // header bytes arrive in address order, byte 0 ends up lowest
    if (rvld_q) hdr_q <= {rdata_q, hdr_q[63:8]};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_ra];
  end

  always_comb begin
    result_o              = res_q;
    result_o.records_held = cnt_q[8:0];
  end

endmodule
`default_nettype wire

// ===== src/vrlr_ctrl.sv =====
`default_nettype none
module vrlr_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  vrlr_pkg::stat_t  stat_i,
  output vrlr_pkg::ctl_t   ctl_o,
  output logic             busy_o,
  output logic             done_o
);

  vrlr_pkg::state_e state_q, state_d, ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vrlr_pkg::ST_IDLE;
      ret_q   <= vrlr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    ctl_o.cmd = vrlr_pkg::CMD_NONE;
    busy_o    = 1'b1;
    done_o    = 1'b0;
    unique case (state_q)
      vrlr_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctl_o.cmd = vrlr_pkg::CMD_LATCH;
          state_d   = vrlr_pkg::ST_DISPATCH;
        end
      end
      vrlr_pkg::ST_DISPATCH: begin
        state_d = vrlr_pkg::ST_DONE;
        unique case (stat_i.op)
          vrlr_pkg::OP_BEGIN: begin
            if (stat_i.pend_zero && !stat_i.too_long) begin
              if (!stat_i.free_short) begin
                state_d = vrlr_pkg::ST_HDR;
              end else if (stat_i.tail_short) begin
                state_d = vrlr_pkg::ST_WRAP_CHK;
              end else begin
                state_d = vrlr_pkg::ST_FREE_CHK;
              end
            end
          end
          vrlr_pkg::OP_DATA: if (!stat_i.pend_zero) ctl_o.cmd = vrlr_pkg::CMD_DATA;
          vrlr_pkg::OP_READ: begin
            if (stat_i.rd_ok) begin
              ret_d   = vrlr_pkg::ST_RD_FIN;
              state_d = vrlr_pkg::ST_FETCH;
            end
          end
          vrlr_pkg::OP_PEEK: if (stat_i.peek_ok) state_d = vrlr_pkg::ST_PEEK_RD;
          vrlr_pkg::OP_CLEAR: ctl_o.cmd = vrlr_pkg::CMD_CLEAR;
          default: ;
        endcase
      end
      vrlr_pkg::ST_WRAP_CHK: begin
        if (stat_i.wrap_drop) begin
          ret_d   = vrlr_pkg::ST_DROP_W;
          state_d = vrlr_pkg::ST_FETCH;
        end else begin
          ctl_o.cmd = vrlr_pkg::CMD_WRAP;
          state_d   = vrlr_pkg::ST_FREE_CHK;
        end
      end
      vrlr_pkg::ST_FREE_CHK: begin
        if (stat_i.free_short) begin
          ret_d   = vrlr_pkg::ST_DROP_F;
          state_d = vrlr_pkg::ST_FETCH;
        end else begin
          state_d = vrlr_pkg::ST_HDR;
        end
      end
      vrlr_pkg::ST_FETCH: begin
        ctl_o.cmd = vrlr_pkg::CMD_FETCH;
        if (stat_i.fetch_last) state_d = vrlr_pkg::ST_FETCH_END;
      end
      vrlr_pkg::ST_FETCH_END: state_d = ret_q;
      vrlr_pkg::ST_DROP_W: begin
        ctl_o.cmd = vrlr_pkg::CMD_DROP;
        state_d   = vrlr_pkg::ST_WRAP_CHK;
      end
      vrlr_pkg::ST_DROP_F: begin
        ctl_o.cmd = vrlr_pkg::CMD_DROP;
        state_d   = vrlr_pkg::ST_FREE_CHK;
      end
      vrlr_pkg::ST_HDR: begin
        ctl_o.cmd = vrlr_pkg::CMD_HDR;
        if (stat_i.hdr_last) state_d = vrlr_pkg::ST_COMMIT;
      end
      vrlr_pkg::ST_COMMIT: begin
        ctl_o.cmd = vrlr_pkg::CMD_COMMIT;
        state_d   = vrlr_pkg::ST_DONE;
      end
      vrlr_pkg::ST_RD_FIN: begin
        ctl_o.cmd = vrlr_pkg::CMD_RD_FIN;
        state_d   = vrlr_pkg::ST_DONE;
      end
      vrlr_pkg::ST_PEEK_RD: begin
        ctl_o.cmd = vrlr_pkg::CMD_PEEK_RD;
        state_d   = vrlr_pkg::ST_PEEK_FIN;
      end
      vrlr_pkg::ST_PEEK_FIN: begin
        ctl_o.cmd = vrlr_pkg::CMD_PEEK_FIN;
        state_d   = vrlr_pkg::ST_DONE;
      end
      vrlr_pkg::ST_DONE: begin
        done_o  = 1'b1;
        state_d = vrlr_pkg::ST_IDLE;
      end
      default: state_d = vrlr_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/variable_record_log_ring.sv =====
// Log ring of variable-length records, oldest dropped to make room.
// Command channel: an item is taken when start is high and busy is low;
// busy then stays high until the result is shown. The result sits on
// result_o for exactly one cycle with result_valid_o high; there is no
// backpressure, the receiver must take it then.
// Config channel: cfg_valid_i/cfg_ready_o write the buffer size (clamped
// to 32..MAX_BUFFER_BYTES) and empty the ring; ready only while idle and
// no item is being started.
// Per item (one byte port to the store): data byte, clear, error: dispatch;
//   peek: a store read; read: 8 header reads, a wait, the finish; record
//   write: HEADER_BYTES header writes, the commit; making room adds checks,
//   a wrap step on a wrap, and 8 header reads, a wait and the drop per
//   dropped record. The next item can start the cycle after the strobe.
// Reset empties the ring and sets the size to 4096 (or the maximum);
// store contents are not cleared and never-written bytes read as unknown.
`default_nettype none
module variable_record_log_ring #(
  parameter int unsigned MAX_BUFFER_BYTES = 4096,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  vrlr_pkg::in_item_t  item_i,
  output logic                result_valid_o,
  output vrlr_pkg::out_item_t result_o,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  [12:0]         cfg_data_i
);

  vrlr_pkg::ctl_t  ctl;
  vrlr_pkg::stat_t stat;

  // a start in the same cycle wins; the write waits until idle again
  assign cfg_ready_o = !busy && !start;

  vrlr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctl_o   (ctl),
    .busy_o  (busy),
    .done_o  (result_valid_o)
  );

  vrlr_datapath #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES),
    .HEADER_BYTES     (HEADER_BYTES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .item_i     (item_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .stat_o     (stat),
    .result_o   (result_o)
  );

endmodule
`default_nettype wire
